@@ design/csps_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csps_pkg
// Shared types, constants and helpers of the column segment pixel sorter.
// ----------------------------------------------------------------------------
package csps_pkg;

    localparam int MAX_SEGMENT = 63;
    localparam int LEN_W       = $clog2(MAX_SEGMENT + 1);
    localparam int ADDR_W      = (MAX_SEGMENT > 1) ? $clog2(MAX_SEGMENT) : 1;
    localparam int COMP_W      = 8;
    localparam int PIX_W       = 3 * COMP_W;
    localparam int SUM_W       = 10;
    localparam int CFG_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SUM = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SUM = 2'd1;

    localparam logic [SUM_W-1:0] MIN_SUM_RESET = 10'd0;
    localparam logic [SUM_W-1:0] MAX_SUM_RESET = 10'd765;

    localparam logic [LEN_W-1:0] SEG_FULL = LEN_W'(MAX_SEGMENT);

    typedef struct packed {
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        pixel_t            pix;
        logic [SUM_W-1:0]  sum;
        logic              hold;
        logic              col_end;
    } seg_cmd_t;

    typedef struct packed {
        pixel_t pix;
        logic   run_last;
        logic   column_done;
    } result_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_INS_CMP,
        B_INS_PUT,
        B_FL_RD,
        B_FL_OUT,
        B_PASS_OUT
    } back_state_t;

    typedef struct packed {
        back_state_t       state;
        logic [LEN_W-1:0]  len;
    } back_status_t;

    function automatic logic [SUM_W-1:0] pix_sum(input pixel_t p);
        return SUM_W'(p.red) + SUM_W'(p.green) + SUM_W'(p.blue);
    endfunction

endpackage
`default_nettype wire

@@ design/csps_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csps_front
// Holds the sum bounds, takes pixels and tags each one as held or passed.
// ----------------------------------------------------------------------------
module csps_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [csps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [csps_pkg::SUM_W-1:0]     cfg_data,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [csps_pkg::PIX_W-1:0]     s_tdata,   // red, green, blue
    input  wire logic                          s_tlast,   // column_end
    output logic                               push_valid,
    input  wire logic                          push_ready,
    output csps_pkg::seg_cmd_t                 push_data
);
    import csps_pkg::*;

    logic [SUM_W-1:0] min_sum_reg, min_sum_next;
    logic [SUM_W-1:0] max_sum_reg, max_sum_next;
    pixel_t           pix;
    logic [SUM_W-1:0] sum;

    assign cfg_ready = 1'b1;

    always_comb begin
        min_sum_next = min_sum_reg;
        max_sum_next = max_sum_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_MIN_SUM: min_sum_next = cfg_data;
                CFG_MAX_SUM: max_sum_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_sum_reg <= MIN_SUM_RESET;
            max_sum_reg <= MAX_SUM_RESET;
        end else begin
            min_sum_reg <= min_sum_next;
            max_sum_reg <= max_sum_next;
        end
    end

    always_comb begin
        pix.red   = s_tdata[COMP_W-1:0];
        pix.green = s_tdata[2*COMP_W-1:COMP_W];
        pix.blue  = s_tdata[3*COMP_W-1:2*COMP_W];
        sum       = pix_sum(pix);
    end

    assign s_tready   = push_ready;
    assign push_valid = s_tvalid;

    always_comb begin
        push_data.pix     = pix;
        push_data.sum     = sum;
        push_data.col_end = s_tlast;
        push_data.hold    = !s_tlast && (sum >= min_sum_reg) && (sum <= max_sum_reg);
    end

endmodule
`default_nettype wire

@@ design/csps_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csps_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module csps_queue (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                push_valid,
    output logic                     push_ready,
    input  wire csps_pkg::seg_cmd_t  push_data,
    output logic                     pop_valid,
    input  wire logic                pop_ready,
    output csps_pkg::seg_cmd_t       pop_data
);
    import csps_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    seg_cmd_t          entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

@@ design/csps_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csps_back
// Segment buffer kept sorted by insertion, flush sequencer and output register.
// ----------------------------------------------------------------------------
module csps_back (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cmd_valid,
    output logic                     cmd_pop,
    input  wire csps_pkg::seg_cmd_t  cmd_in,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output csps_pkg::result_t        out_data,
    output csps_pkg::back_status_t   status
);
    import csps_pkg::*;

    pixel_t            seg_mem [MAX_SEGMENT];
    pixel_t            rd_data_reg;

    back_state_t       state_reg, state_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic              full_reg, full_next;
    seg_cmd_t          cmd_reg, cmd_next;
    logic              out_valid_reg;
    result_t           out_reg;

    logic              rd_en, wr_en, out_load;
    logic [ADDR_W-1:0] rd_addr, wr_addr;
    pixel_t            wr_data;
    result_t           load_data;

    logic              out_free, greater, last_idx, ins_full;
    logic [LEN_W-1:0]  len_inc;
    logic [ADDR_W-1:0] len_top;

    assign out_free = !out_valid_reg || out_ready;
    assign greater  = pix_sum(rd_data_reg) > cmd_reg.sum;
    assign len_top  = ADDR_W'(len_reg - LEN_W'(1));
    assign last_idx = (idx_reg == len_top);
    assign len_inc  = len_reg + LEN_W'(1);
    assign ins_full = (len_inc == SEG_FULL);

    // next state
    always_comb begin
        state_next = state_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        full_next  = full_reg;
        cmd_next   = cmd_reg;
        case (state_reg)
            B_IDLE: begin
                if (cmd_valid) begin
                    cmd_next = cmd_in;
                    if (cmd_in.hold) begin
                        if (len_reg == '0) begin
                            len_next = len_inc;
                            if (ins_full) begin
                                state_next = B_FL_RD;
                                idx_next   = '0;
                                full_next  = 1'b1;
                            end
                        end else begin
                            idx_next   = len_top;
                            state_next = B_INS_CMP;
                        end
                    end else if (len_reg != '0) begin
                        state_next = B_FL_RD;
                        idx_next   = '0;
                        full_next  = 1'b0;
                    end else begin
                        state_next = B_PASS_OUT;
                    end
                end
            end
            B_INS_CMP: begin
                if (greater) begin
                    if (idx_reg == '0) begin
                        state_next = B_INS_PUT;
                    end else begin
                        idx_next = idx_reg - ADDR_W'(1);
                    end
                end else begin
                    len_next = len_inc;
                    if (ins_full) begin
                        state_next = B_FL_RD;
                        idx_next   = '0;
                        full_next  = 1'b1;
                    end else begin
                        state_next = B_IDLE;
                    end
                end
            end
            B_INS_PUT: begin
                len_next = len_inc;
                if (ins_full) begin
                    state_next = B_FL_RD;
                    idx_next   = '0;
                    full_next  = 1'b1;
                end else begin
                    state_next = B_IDLE;
                end
            end
            B_FL_RD: begin
                state_next = B_FL_OUT;
            end
            B_FL_OUT: begin
                if (out_free) begin
                    if (last_idx) begin
                        len_next   = '0;
                        state_next = full_reg ? B_IDLE : B_PASS_OUT;
                    end else begin
                        idx_next   = idx_reg + ADDR_W'(1);
                        state_next = B_FL_RD;
                    end
                end
            end
            B_PASS_OUT: begin
                if (out_free) begin
                    state_next = B_IDLE;
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    // outputs and buffer access
    always_comb begin
        cmd_pop   = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = '0;
        wr_en     = 1'b0;
        wr_addr   = '0;
        wr_data   = cmd_reg.pix;
        out_load  = 1'b0;
        load_data = '{pix: rd_data_reg, run_last: 1'b0, column_done: 1'b0};
        case (state_reg)
            B_IDLE: begin
                cmd_pop = cmd_valid;
                if (cmd_valid && cmd_in.hold) begin
                    if (len_reg == '0) begin
                        wr_en   = 1'b1;
                        wr_data = cmd_in.pix;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = len_top;
                    end
                end
            end
            B_INS_CMP: begin
                wr_en   = 1'b1;
                wr_addr = idx_reg + ADDR_W'(1);
                if (greater) begin
                    wr_data = rd_data_reg;
                    if (idx_reg != '0) begin
                        rd_en   = 1'b1;
                        rd_addr = idx_reg - ADDR_W'(1);
                    end
                end
            end
            B_INS_PUT: begin
                wr_en = 1'b1;
            end
            B_FL_RD: begin
                rd_en   = 1'b1;
                rd_addr = idx_reg;
            end
            B_FL_OUT: begin
                out_load           = out_free;
                load_data.run_last = full_reg && last_idx;
            end
            B_PASS_OUT: begin
                out_load  = out_free;
                load_data = '{pix: cmd_reg.pix, run_last: 1'b1,
                              column_done: cmd_reg.col_end};
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            len_reg       <= '0;
            full_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            len_reg   <= len_next;
            full_reg  <= full_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        cmd_reg <= cmd_next;
        if (out_load) begin
            out_reg <= load_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            seg_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= seg_mem[rd_addr];
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_data     = out_reg;
    assign status.state = state_reg;
    assign status.len   = len_reg;

endmodule
`default_nettype wire

@@ design/column_segment_pixel_sorter.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// column_segment_pixel_sorter
// Sorts in-range runs of a pixel column by r+g+b sum and passes other pixels.
// ----------------------------------------------------------------------------
// channel   dir  data                          side bits
// s_*       in   tdata: red, green, blue       tlast: column_end
// m_*       out  tdata: out_red, green, blue   tlast: run_last, tuser: column_done
// cfg_*     in   cfg_data: bound value         cfg_index: 0 min_sum, 1 max_sum
//
// a held pixel is inserted into the sorted buffer, one entry moved per cycle,
// larger entries shifted up from the top through the registered read of the buffer memory
// a flush reads each buffered pixel through a registered read, then loads the output
// a passed pixel goes straight to the output load; a two-entry queue decouples front and back
// reset sets the bounds to 0 and 765 and clears the fill count and the queue; buffer contents stay
// stalls on m_tready hold the output register and back up into the queue
// ----------------------------------------------------------------------------
module column_segment_pixel_sorter (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [csps_pkg::PIX_W-1:0]     s_tdata,   // red, green, blue
    input  wire logic                          s_tlast,   // column_end
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [csps_pkg::PIX_W-1:0]          m_tdata,   // out_red, out_green, out_blue
    output logic                               m_tlast,   // run_last
    output logic                               m_tuser,   // column_done
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [csps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [csps_pkg::SUM_W-1:0]     cfg_data
);
    import csps_pkg::*;

    logic         push_valid, push_ready;
    seg_cmd_t     push_data;
    logic         pop_valid, pop_ready;
    seg_cmd_t     pop_data;
    result_t      result;
    back_status_t status;

    csps_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    csps_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    csps_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (pop_valid),
        .cmd_pop   (pop_ready),
        .cmd_in    (pop_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (result),
        .status    (status)
    );

    assign m_tdata = {result.pix.blue, result.pix.green, result.pix.red};
    assign m_tlast = result.run_last;
    assign m_tuser = result.column_done;

    a_len_below_full: assert property (@(posedge aclk) disable iff (!aresetn)
        status.state == B_IDLE |-> status.len < SEG_FULL)
        else $error("segment buffer full while back is idle");

    a_done_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("column end result not marked last of run");

    a_inner_from_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> status.state == B_FL_RD || status.state == B_FL_OUT
                                 || status.state == B_PASS_OUT)
        else $error("non-final result outside a flush");

    a_pop_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        pop_ready |-> status.state == B_IDLE && pop_valid)
        else $error("queue popped while back is busy");

endmodule
`default_nettype wire

@@ tb/column_segment_pixel_sorter_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// column_segment_pixel_sorter_test
// Streams pixel columns through the sorter under several bound settings and
// random backpressure, predicts every emitted pixel with a stable sorted run
// buffer kept in the bench, and checks each result transfer field by field.
// ----------------------------------------------------------------------------
module column_segment_pixel_sorter_test;

    import csps_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
    localparam int SETTLE_CYCLES = 256;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int HOLD_CYCLES   = 400;

    typedef struct packed {
        pixel_t pix;
        logic   col_end;
    } column_pixel_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [PIX_W-1:0]     s_tdata   = '0;
    logic                 s_tlast   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [PIX_W-1:0]     m_tdata;
    logic                 m_tlast;
    logic                 m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [SUM_W-1:0]     cfg_data  = '0;

    column_pixel_t pixel_feed[$];
    result_t       due_results[$];

    // bench copy of the block state
    pixel_t           held_run[MAX_SEGMENT];
    int               held_len  = 0;
    logic [SUM_W-1:0] low_bound  = MIN_SUM_RESET;
    logic [SUM_W-1:0] high_bound = MAX_SUM_RESET;

    int send_idle_pct = 27;
    int recv_idle_pct = 85;
    bit hold_request  = 1'b0;
    int hold_left     = 0;
    int mismatches    = 0;
    int cycle_count   = 0;

    column_segment_pixel_sorter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic int brightness(pixel_t p);
        return int'(p.red) + int'(p.green) + int'(p.blue);
    endfunction

    function automatic void release_run(bit ends_item);
        result_t r;
        for (int i = 0; i < held_len; i++) begin
            r.pix         = held_run[i];
            r.run_last    = ends_item && (i == held_len - 1);
            r.column_done = 1'b0;
            due_results.insert(due_results.size(), r);
        end
        held_len = 0;
    endfunction

    function automatic void sort_column_pixel(column_pixel_t item);
        int      s;
        int      pos;
        result_t r;
        s = brightness(item.pix);
        if (!item.col_end && s >= int'(low_bound) && s <= int'(high_bound)) begin
            // stable insert: equal sums stay in arrival order
            pos = held_len;
            while (pos > 0 && brightness(held_run[pos-1]) > s) begin
                held_run[pos] = held_run[pos-1];
                pos--;
            end
            held_run[pos] = item.pix;
            held_len++;
            if (held_len == MAX_SEGMENT) begin
                release_run(1'b1);
            end
        end else begin
            release_run(1'b0);
            r.pix         = item.pix;
            r.run_last    = 1'b1;
            r.column_done = item.col_end;
            due_results.insert(due_results.size(), r);
        end
    endfunction

    // input side
    always @(posedge aclk) begin
        column_pixel_t item;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                item = pixel_feed.pop_front();
                sort_column_pixel(item);
            end
            if (!s_tvalid || s_tready) begin
                if (pixel_feed.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    item = pixel_feed[0];
                    s_tvalid <= 1'b1;
                    s_tdata  <= {item.pix.blue, item.pix.green, item.pix.red};
                    s_tlast  <= item.col_end;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result side
    always @(posedge aclk) begin
        result_t want;
        bit      bad;
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (m_tvalid && m_tready) begin
            if (due_results.size() == 0) begin
                if (mismatches < 10) begin
                    $display("%0t unexpected transfer: rgb %0d %0d %0d last %b done %b",
                             $realtime, m_tdata[7:0], m_tdata[15:8], m_tdata[23:16],
                             m_tlast, m_tuser);
                end
                mismatches++;
            end else begin
                want = due_results.pop_front();
                bad  = (m_tdata[7:0] !== want.pix.red) || (m_tdata[15:8] !== want.pix.green)
                    || (m_tdata[23:16] !== want.pix.blue) || (m_tlast !== want.run_last)
                    || (m_tuser !== want.column_done);
                if (bad) begin
                    if (mismatches < 10) begin
                        $display("%0t mismatch: exp rgb %0d %0d %0d last %b done %b", $realtime,
                                 want.pix.red, want.pix.green, want.pix.blue,
                                 want.run_last, want.column_done);
                        $display("             got rgb %0d %0d %0d last %b done %b",
                                 m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tlast, m_tuser);
                    end
                    mismatches++;
                end
            end
        end
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** column_segment_pixel_sorter: FAILED **");
            $finish;
        end
    end

    task automatic push_pixel(int r, int g, int b, bit col_end);
        column_pixel_t item;
        item.pix.red   = 8'(r);
        item.pix.green = 8'(g);
        item.pix.blue  = 8'(b);
        item.col_end   = col_end;
        pixel_feed.insert(pixel_feed.size(), item);
    endtask

    task automatic wait_quiet();
        while (pixel_feed.size() > 0 || s_tvalid || due_results.size() > 0) begin
            @(posedge aclk);
        end
        // a held pixel may still be sliding into place
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_bound(logic [CFG_IDX_W-1:0] idx, logic [SUM_W-1:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == CFG_MIN_SUM) begin
            low_bound = value;
        end else if (idx == CFG_MAX_SUM) begin
            high_bound = value;
        end
    endtask

    function automatic pixel_t pixel_with_sum(int total);
        pixel_t p;
        int     rest;
        p.red   = 8'($urandom_range(total > 255 ? 255 : total, total > 510 ? total - 510 : 0));
        rest    = total - int'(p.red);
        p.green = 8'($urandom_range(rest > 255 ? 255 : rest, rest > 255 ? rest - 255 : 0));
        p.blue  = 8'(rest - int'(p.green));
        return p;
    endfunction

    function automatic pixel_t pick_pixel(bit want_in, int tie_sum);
        pixel_t p;
        int     top;
        top = (int'(high_bound) > 765) ? 765 : int'(high_bound);
        if (want_in && int'(low_bound) <= top) begin
            if (tie_sum >= int'(low_bound) && tie_sum <= top && $urandom_range(3) == 0) begin
                return pixel_with_sum(tie_sum);
            end
            return pixel_with_sum($urandom_range(top, int'(low_bound)));
        end
        p = pixel_t'(PIX_W'($urandom()));
        if ($urandom_range(4) == 0) begin
            p.red   = $urandom_range(1) ? 8'hff : 8'h00;
            p.green = $urandom_range(1) ? 8'hff : 8'h00;
            p.blue  = $urandom_range(1) ? 8'hff : 8'h00;
        end
        return p;
    endfunction

    task automatic queue_column(int len, int in_pct, bit open_end);
        column_pixel_t item;
        int            tie_sum;
        tie_sum = $urandom_range(765);
        for (int i = 0; i < len; i++) begin
            item.pix     = pick_pixel($urandom_range(99) < in_pct, tie_sum);
            item.col_end = (i == len - 1) && !open_end;
            pixel_feed.insert(pixel_feed.size(), item);
        end
    endtask

    task automatic run_phase(int lo, int hi, int s_idle, int r_idle, int count,
                             int long_cols, bit hold_off);
        int queued;
        int len;
        wait_quiet();
        write_bound(CFG_MIN_SUM, SUM_W'(lo));
        write_bound(CFG_MAX_SUM, SUM_W'(hi));
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        queued = 0;
        for (int i = 0; i < long_cols; i++) begin
            len = $urandom_range(70, 63);
            queue_column(len, 96, 1'b0);
            queued += len;
        end
        while (queued < count) begin
            len = $urandom_range(14, 1);
            queue_column(len, 70, (queued + len >= count) && $urandom_range(1));
            queued += len;
        end
        if (hold_off) begin
            hold_request = 1'b1;
        end
    endtask

    initial begin
        int lo;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // default bounds: whole range held, ties, column end flush, lone end pixel
        push_pixel(255, 255, 255, 1'b0);
        push_pixel(0, 0, 0, 1'b0);
        push_pixel(10, 20, 30, 1'b0);
        push_pixel(5, 5, 50, 1'b0);
        push_pixel(1, 2, 3, 1'b1);
        push_pixel(128, 128, 128, 1'b1);
        wait_quiet();

        // bound edges, out-of-range pixel ends a run
        write_bound(CFG_MIN_SUM, 10'd100);
        write_bound(CFG_MAX_SUM, 10'd400);
        push_pixel(0, 0, 99, 1'b0);
        push_pixel(0, 0, 100, 1'b0);
        push_pixel(200, 200, 0, 1'b0);
        push_pixel(200, 200, 1, 1'b0);
        push_pixel(50, 50, 50, 1'b0);
        wait_quiet();

        // bound change while a run is held, spare indexes ignored
        write_bound(CFG_MAX_SUM, 10'd1023);
        write_bound(CFG_SPARE_A, 10'd0);
        write_bound(CFG_SPARE_B, 10'd1023);
        push_pixel(255, 255, 255, 1'b0);
        push_pixel(0, 0, 0, 1'b1);
        wait_quiet();

        // inverted bounds pass everything
        write_bound(CFG_MIN_SUM, 10'd500);
        write_bound(CFG_MAX_SUM, 10'd200);
        push_pixel(100, 100, 100, 1'b0);
        push_pixel(255, 0, 0, 1'b0);
        push_pixel(0, 255, 255, 1'b1);
        wait_quiet();

        // bounds above the largest sum
        write_bound(CFG_MIN_SUM, 10'd1023);
        write_bound(CFG_MAX_SUM, 10'd1023);
        push_pixel(255, 255, 255, 1'b0);
        push_pixel(0, 0, 0, 1'b0);

        run_phase(0, 765, 27, 85, 50, 1, 1'b0);
        run_phase(200, 500, 27, 85, 35, 0, 1'b0);
        run_phase(0, 1023, 27, 85, 50, 1, 1'b0);
        run_phase(765, 765, 85, 27, 30, 0, 1'b0);
        run_phase(300, 300, 85, 27, 35, 0, 1'b0);
        wait_quiet();
        write_bound(CFG_SPARE_A, SUM_W'($urandom()));
        write_bound(CFG_SPARE_B, SUM_W'($urandom()));
        lo = $urandom_range(400);
        run_phase(lo, lo + $urandom_range(365), 85, 27, 35, 0, 1'b0);
        run_phase(600, 100, 0, 0, 45, 0, 1'b1);
        run_phase(1023, 0, 0, 0, 25, 0, 1'b0);
        run_phase(100, 700, 0, 0, 60, 1, 1'b0);
        wait_quiet();

        if (mismatches == 0 && due_results.size() == 0) begin
            $display("** column_segment_pixel_sorter: PASSED **");
        end else begin
            $display("** column_segment_pixel_sorter: FAILED **");
        end
        $finish;
    end

endmodule
